### hw/rtl/skvt_pkg.sv
// Package for the sorted key/value table: sizes, field widths, command and
// status codes, and the control and collect structs passed along the cell row.
// No dependencies.
package skvt_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned OCNT_W   = 9;
  localparam int unsigned S_DATA_W = 80;
  localparam int unsigned M_DATA_W = 88;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_INS,
    CELL_REM
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_HOLD
  } state_e;

  // Broadcast to every cell in each cycle.
  typedef struct packed {
    cell_op_e         op;
    word_t            key;
    word_t            value;
    logic [CMP_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic             rd_en;
    logic             find_en;
    logic             load;
    logic             sweep;
  } cell_ctl_t;

  // Result contribution; at most one cell loads a nonzero one per item.
  typedef struct packed {
    logic             found;
    word_t            key;
    word_t            value;
    logic [IDX_W-1:0] pos;
  } coll_t;

endpackage

### hw/rtl/skvt_cell.sv
// One entry of the sorted table: key/value registers with compare-and-shift
// logic, plus one stage of the result collect chain. Depends on skvt_pkg.
module skvt_cell
  import skvt_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  logic             prev_ge_i,
  input  word_t            prev_key_i,
  input  word_t            prev_val_i,
  input  word_t            next_key_i,
  input  word_t            next_val_i,
  input  coll_t            next_coll_i,
  output logic             ge_o,
  output word_t            key_o,
  output word_t            val_o,
  output coll_t            coll_o
);

  word_t key_q, key_d;
  word_t val_q, val_d;
  coll_t coll_q, coll_d;

  logic [CMP_W-1:0] idx_ext;
  logic             valid;
  logic             bound;
  logic             sel_rd;
  logic             hit;

  assign idx_ext = CMP_W'(idx_i);
  assign valid   = idx_ext < CMP_W'(ctl_i.count);
  // Entries are sorted, so this flag is low before the insert point and high from it on.
  assign ge_o    = !valid || (key_q >= ctl_i.key);
  assign bound   = ge_o && !prev_ge_i;
  assign sel_rd  = ctl_i.rd_en && (idx_ext == ctl_i.pos);
  assign hit     = ctl_i.find_en && bound && valid && (key_q == ctl_i.key);

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (prev_ge_i) begin
          key_d = prev_key_i;
          val_d = prev_val_i;
        end else if (ge_o) begin
          key_d = ctl_i.key;
          val_d = ctl_i.value;
        end
      end
      CELL_REM: begin
        if (idx_ext >= ctl_i.pos) begin
          key_d = next_key_i;
          val_d = next_val_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    coll_d = coll_q;
    if (ctl_i.load) begin
      coll_d.found = hit;
      coll_d.key   = sel_rd ? key_q : '0;
      coll_d.value = sel_rd ? val_q : '0;
      coll_d.pos   = hit ? idx_i : '0;
    end else if (ctl_i.sweep) begin
      coll_d = coll_t'(coll_q | next_coll_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    coll_q <= coll_d;
  end

  assign key_o  = key_q;
  assign val_o  = val_q;
  assign coll_o = coll_q;

endmodule

### hw/rtl/sorted_key_value_table.sv
// Sorted key/value table. Up to CAPACITY signed key/value pairs are kept in
// ascending key order in a row of cells; insert, remove and set change the
// row with all cells acting at once (set is a removal followed by an
// insert), while get and find leave it as it is. The answer is then gathered
// by a collect chain that ORs each cell's contribution toward cell 0, one
// cell per cycle; a new item is taken only after that walk down the row ends
// and its result is loaded into the output register. A new item is taken
// while the previous result still waits on the output. Entries at or beyond
// the count are never read out. Depends on skvt_pkg and skvt_cell.
module sorted_key_value_table
  import skvt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // cmd[2:0], key[34:3], value[66:35], position[74:67], zero fill above
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], found[2], out_key[34:3], out_value[66:35],
  // out_position[74:67], count[83:75], zero fill above
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic             pend_ins_q, pend_ins_d;
  logic             is_find_q, is_find_d;
  status_e          stat_q, stat_d;
  word_t            item_key_q, item_val_q;

  logic             m_valid_q, m_valid_d;
  status_e          res_stat_q;
  logic             res_found_q;
  word_t            res_key_q, res_val_q;
  logic [POS_W-1:0] res_pos_q;
  logic [OCNT_W-1:0] res_count_q;

  logic [CMD_W-1:0] in_cmd;
  word_t            in_key, in_val;
  logic [POS_W-1:0] in_pos;
  logic [CMP_W-1:0] pos_ext;
  logic             acc;
  logic             full;
  logic             bad_pos;
  logic             sweep_last;
  logic             out_load;
  cell_ctl_t        ctl;

  logic  ge_chain   [0:CAPACITY];
  word_t key_chain  [0:CAPACITY+1];
  word_t val_chain  [0:CAPACITY+1];
  coll_t coll_chain [0:CAPACITY];

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_key  = s_axis_tdata[34:3];
  assign in_val  = s_axis_tdata[66:35];
  assign in_pos  = s_axis_tdata[74:67];
  assign pos_ext = CMP_W'(in_pos);

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc        = s_axis_tvalid && s_axis_tready;
  assign full       = count_q == CNT_W'(CAPACITY);
  assign bad_pos    = pos_ext >= CMP_W'(count_q);
  assign sweep_last = sweep_cnt_q == IDX_W'(CAPACITY - 2);
  assign out_load   = (state_q == S_HOLD) && (!m_valid_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc) state_d = S_SWEEP;
      S_SWEEP: if (sweep_last) state_d = S_HOLD;
      S_HOLD:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell control and item bookkeeping.
  always_comb begin
    ctl          = '0;
    ctl.op       = CELL_NOP;
    ctl.key      = acc ? in_key : item_key_q;
    ctl.value    = acc ? in_val : item_val_q;
    ctl.pos      = pos_ext;
    ctl.count    = count_q;
    ctl.load     = acc;
    ctl.sweep    = (state_q == S_SWEEP);
    pend_ins_d   = 1'b0;
    is_find_d    = is_find_q;
    stat_d       = stat_q;
    sweep_cnt_d  = (state_q == S_SWEEP) ? sweep_cnt_q + 1'b1 : '0;

    if (acc) begin
      is_find_d = 1'b0;
      stat_d    = ST_OK;
      unique case (in_cmd) inside
        CMD_INSERT: begin
          if (full) stat_d = ST_FULL;
          else ctl.op = CELL_INS;
        end
        CMD_REMOVE, CMD_GET, CMD_SET: begin
          if (bad_pos) begin
            stat_d = ST_BADPOS;
          end else begin
            ctl.rd_en = 1'b1;
            if (in_cmd != CMD_GET) ctl.op = CELL_REM;
            pend_ins_d = (in_cmd == CMD_SET);
          end
        end
        CMD_FIND: begin
          ctl.find_en = 1'b1;
          is_find_d   = 1'b1;
        end
        default: ;
      endcase
    end else if (state_q == S_SWEEP && pend_ins_q) begin
      // Second half of a set: insert the new pair after the removal.
      ctl.op = CELL_INS;
    end

    count_d = count_q;
    if (ctl.op == CELL_INS) count_d = count_q + 1'b1;
    else if (ctl.op == CELL_REM) count_d = count_q - 1'b1;

    m_valid_d = m_valid_q;
    if (out_load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sweep_cnt_q <= '0;
      pend_ins_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sweep_cnt_q <= sweep_cnt_d;
      pend_ins_q  <= pend_ins_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_find_q <= is_find_d;
    stat_q    <= stat_d;
    if (acc) begin
      item_key_q <= in_key;
      item_val_q <= in_val;
    end
    if (out_load) begin
      res_stat_q  <= (is_find_q && !coll_chain[0].found) ? ST_NOTFOUND : stat_q;
      res_found_q <= coll_chain[0].found;
      res_key_q   <= coll_chain[0].key;
      res_val_q   <= coll_chain[0].value;
      res_pos_q   <= POS_W'(coll_chain[0].pos);
      res_count_q <= OCNT_W'(count_q);
    end
  end

  // Cell row.
  assign ge_chain[0]            = 1'b0;
  assign key_chain[0]           = '0;
  assign val_chain[0]           = '0;
  assign key_chain[CAPACITY+1]  = '0;
  assign val_chain[CAPACITY+1]  = '0;
  assign coll_chain[CAPACITY]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctl_i       (ctl),
      .prev_ge_i   (ge_chain[i]),
      .prev_key_i  (key_chain[i]),
      .prev_val_i  (val_chain[i]),
      .next_key_i  (key_chain[i+2]),
      .next_val_i  (val_chain[i+2]),
      .next_coll_i (coll_chain[i+1]),
      .ge_o        (ge_chain[i+1]),
      .key_o       (key_chain[i+1]),
      .val_o       (val_chain[i+1]),
      .coll_o      (coll_chain[i])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, res_count_q, res_pos_q, res_val_q, res_key_q,
                          res_found_q, res_stat_q};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_ins_q |-> state_q == S_SWEEP)
    else $error("pending insert outside the sweep");

  a_set_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_ins_q |-> $past(ctl.op) == CELL_REM)
    else $error("set insert without a preceding removal");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && res_found_q |-> res_stat_q == ST_OK)
    else $error("found reported with an error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && res_stat_q == ST_FULL |-> res_count_q == OCNT_W'(CAPACITY))
    else $error("full status with a table that is not full");

endmodule
